// ===== design/labop_pkg.sv =====
// Shared types, constants and datapath command codes for the buffer offset planner.
`default_nettype none

package labop_pkg;

  localparam int MAX_BUFFERS = 64;
  localparam int IDX_W = $clog2(MAX_BUFFERS);
  localparam int CNT_W = $clog2(MAX_BUFFERS + 1);

  localparam logic [3:0] ALIGN_RESET = 4'd8;
  localparam logic [3:0] ALIGN_MAX = 4'd12;

  localparam logic [1:0] FUNC_RECORD = 2'd0;
  localparam logic [1:0] FUNC_REMOVE = 2'd1;
  localparam logic [1:0] FUNC_PLAN = 2'd2;

  localparam logic [2:0] STAT_OK = 3'd0;
  localparam logic [2:0] STAT_ZERO_SIZE = 3'd1;
  localparam logic [2:0] STAT_FULL = 3'd2;
  localparam logic [2:0] STAT_NOT_FOUND = 3'd3;
  localparam logic [2:0] STAT_EMPTY = 3'd4;

  // Datapath commands
  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_NOP = 4'd0;
  localparam logic [OP_W-1:0] OP_LOAD = 4'd1;
  localparam logic [OP_W-1:0] OP_ENT_RD = 4'd2;
  localparam logic [OP_W-1:0] OP_SCAN_EV = 4'd3;
  localparam logic [OP_W-1:0] OP_COMMIT = 4'd4;
  localparam logic [OP_W-1:0] OP_PLAN_INIT = 4'd5;
  localparam logic [OP_W-1:0] OP_SEL_EV = 4'd6;
  localparam logic [OP_W-1:0] OP_SEL_DONE = 4'd7;
  localparam logic [OP_W-1:0] OP_FIT_RD = 4'd8;
  localparam logic [OP_W-1:0] OP_FIT_EV = 4'd9;
  localparam logic [OP_W-1:0] OP_INS_START = 4'd10;
  localparam logic [OP_W-1:0] OP_INS_RD = 4'd11;
  localparam logic [OP_W-1:0] OP_INS_EV = 4'd12;
  localparam logic [OP_W-1:0] OP_INS_PUT = 4'd13;
  localparam logic [OP_W-1:0] OP_EMIT = 4'd14;
  localparam logic [OP_W-1:0] OP_NEXT = 4'd15;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] buffer_id;
    logic [15:0] use_index;
    logic [31:0] byte_size;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] placed_id;
    logic [39:0] placed_offset;
    logic [39:0] pool_size;
    logic        final_result;
  } out_item_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       size_zero;
    logic       idx_last;
    logic       hit_now;
    logic       table_empty;
    logic       fit_done;
    logic       fit_break;
    logic       ins_head;
    logic       ins_move;
    logic       res_final;
  } dp_stat_t;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] first;
    logic [15:0] last;
    logic [31:0] size;
  } entry_t;

  typedef struct packed {
    logic [39:0] off;
    logic [39:0] pend;
    logic [15:0] first;
    logic [15:0] last;
  } placed_t;

endpackage

`default_nettype wire

// ===== design/labop_dp.sv =====
// Datapath: buffer table, placed-buffer list, scan counters and result register.
`default_nettype none

module labop_dp (
  input  wire                   clk,
  input  wire                   rst,
  input  labop_pkg::cmd_t       cmd,
  output labop_pkg::dp_stat_t   st,
  input  labop_pkg::in_item_t   in_data,
  output labop_pkg::out_item_t  out_data,
  input  wire                   cfg_wr_en,
  input  wire  [3:0]            cfg_wr_data
);
  import labop_pkg::*;

  logic [3:0]             align;
  logic [MAX_BUFFERS-1:0] valid;
  logic [MAX_BUFFERS-1:0] planned;
  logic [CNT_W-1:0]       count;
  logic [IDX_W-1:0]       idx;
  in_item_t               in_r;
  out_item_t              res;
  logic                   hit;
  logic [IDX_W-1:0]       hit_idx;
  entry_t                 hit_ent;
  logic                   free_found;
  logic [IDX_W-1:0]       free_idx;
  logic                   best_found;
  logic [IDX_W-1:0]       best_idx;
  entry_t                 best;
  logic [63:0]            best_key;
  logic [39:0]            sz;
  logic [39:0]            cur;
  logic [39:0]            pool;
  logic [CNT_W-1:0]       placed_n;
  logic [CNT_W-1:0]       k;
  logic [CNT_W-1:0]       j;
  logic [CNT_W-1:0]       ins_j;

  entry_t                 ent_mem [MAX_BUFFERS];
  entry_t                 erd;
  placed_t                pl_mem [MAX_BUFFERS];
  placed_t                prd;

  logic                   ent_we;
  logic [IDX_W-1:0]       ent_waddr;
  entry_t                 ent_wdata;
  logic                   pl_we;
  logic                   pl_re;
  logic [IDX_W-1:0]       pl_waddr;
  logic [IDX_W-1:0]       pl_raddr;
  placed_t                pl_wdata;
  placed_t                pl_new;
  entry_t                 merged;
  logic [63:0]            key;
  logic [3:0]             lg;
  logic [12:0]            mask;
  logic [39:0]            aligned;
  logic [39:0]            cur_plus;
  logic [39:0]            pool_next;
  logic [CNT_W-1:0]       ins_prev;
  logic                   overlap;
  logic                   is_last;

  // Derived values
  always_comb begin
    lg = (align > ALIGN_MAX) ? ALIGN_MAX : align;
    mask = ~(13'h1fff << lg);
    aligned = (40'(best.size) + 40'(mask)) & ~40'(mask);
    cur_plus = cur + sz;
    pool_next = (cur_plus > pool) ? cur_plus : pool;
    key = {erd.size, ~erd.first, ~erd.id};
    overlap = (best.first <= prd.last) && (prd.first <= best.last);
    ins_prev = ins_j - CNT_W'(1);
    is_last = (idx == IDX_W'(MAX_BUFFERS - 1));
    merged.id = hit_ent.id;
    merged.first = (in_r.use_index < hit_ent.first) ? in_r.use_index : hit_ent.first;
    merged.last = (in_r.use_index > hit_ent.last) ? in_r.use_index : hit_ent.last;
    merged.size = (in_r.byte_size > hit_ent.size) ? in_r.byte_size : hit_ent.size;
    pl_new.off = cur;
    pl_new.pend = cur_plus;
    pl_new.first = best.first;
    pl_new.last = best.last;
  end

  // Status toward the controller
  always_comb begin
    st.func = in_r.func;
    st.size_zero = (in_r.byte_size == 32'd0);
    st.idx_last = is_last;
    st.hit_now = valid[idx] && (erd.id == in_r.buffer_id);
    st.table_empty = (count == '0);
    st.fit_done = (j == placed_n);
    st.fit_break = overlap && (cur_plus <= prd.off);
    st.ins_head = (ins_j == '0);
    st.ins_move = (prd.off > cur);
    st.res_final = res.final_result;
  end

  // Memory write and read selection
  always_comb begin
    ent_we = 1'b0;
    ent_waddr = hit_idx;
    ent_wdata = merged;
    if (cmd.op == OP_COMMIT && in_r.func == FUNC_RECORD) begin
      if (hit) begin
        ent_we = 1'b1;
      end else if (free_found) begin
        ent_we = 1'b1;
        ent_waddr = free_idx;
        ent_wdata = '{id: in_r.buffer_id, first: in_r.use_index,
                      last: in_r.use_index, size: in_r.byte_size};
      end
    end
    pl_we = (cmd.op == OP_INS_EV) || (cmd.op == OP_INS_PUT);
    pl_waddr = ins_j[IDX_W-1:0];
    pl_wdata = (cmd.op == OP_INS_EV && st.ins_move) ? prd : pl_new;
    pl_re = (cmd.op == OP_FIT_RD) || (cmd.op == OP_INS_RD);
    pl_raddr = (cmd.op == OP_FIT_RD) ? j[IDX_W-1:0] : ins_prev[IDX_W-1:0];
  end

  // Buffer table memory
  always_ff @(posedge clk) begin
    if (ent_we) ent_mem[ent_waddr] <= ent_wdata;
    if (cmd.op == OP_ENT_RD) erd <= ent_mem[idx];
  end

  // Placed list memory, kept in ascending offset order
  always_ff @(posedge clk) begin
    if (pl_we) pl_mem[pl_waddr] <= pl_wdata;
    if (pl_re) prd <= pl_mem[pl_raddr];
  end

  // Registers
  always_ff @(posedge clk) begin
    if (rst) begin
      align <= ALIGN_RESET;
      valid <= '0;
      planned <= '0;
      count <= '0;
      idx <= '0;
      hit <= 1'b0;
      free_found <= 1'b0;
      best_found <= 1'b0;
      placed_n <= '0;
      k <= '0;
      j <= '0;
      ins_j <= '0;
    end else begin
      if (cfg_wr_en) align <= cfg_wr_data;
      unique case (cmd.op)
        OP_LOAD: begin
          in_r <= in_data;
          idx <= '0;
          hit <= 1'b0;
          free_found <= 1'b0;
          res <= '{status: STAT_ZERO_SIZE, placed_id: in_data.buffer_id,
                   placed_offset: '0, pool_size: '0, final_result: 1'b1};
        end
        OP_SCAN_EV: begin
          if (st.hit_now) begin
            hit <= 1'b1;
            hit_idx <= idx;
            hit_ent <= erd;
          end else begin
            if (!valid[idx] && !free_found) begin
              free_found <= 1'b1;
              free_idx <= idx;
            end
            idx <= is_last ? '0 : idx + IDX_W'(1);
          end
        end
        OP_COMMIT: begin
          res.placed_offset <= '0;
          res.pool_size <= '0;
          res.final_result <= 1'b1;
          res.placed_id <= in_r.buffer_id;
          if (in_r.func == FUNC_RECORD) begin
            if (hit) begin
              res.status <= STAT_OK;
            end else if (free_found) begin
              res.status <= STAT_OK;
              valid[free_idx] <= 1'b1;
              count <= count + CNT_W'(1);
            end else begin
              res.status <= STAT_FULL;
            end
          end else begin
            if (hit) begin
              res.status <= STAT_OK;
              valid[hit_idx] <= 1'b0;
              count <= count - CNT_W'(1);
            end else begin
              res.status <= STAT_NOT_FOUND;
            end
          end
        end
        OP_PLAN_INIT: begin
          planned <= '0;
          placed_n <= '0;
          k <= '0;
          pool <= '0;
          idx <= '0;
          best_found <= 1'b0;
          res <= '{status: STAT_EMPTY, placed_id: '0, placed_offset: '0,
                   pool_size: '0, final_result: 1'b1};
        end
        OP_SEL_EV: begin
          if (valid[idx] && !planned[idx] && (!best_found || key > best_key)) begin
            best_found <= 1'b1;
            best <= erd;
            best_idx <= idx;
            best_key <= key;
          end
          idx <= is_last ? '0 : idx + IDX_W'(1);
        end
        OP_SEL_DONE: begin
          planned[best_idx] <= 1'b1;
          sz <= aligned;
          cur <= '0;
          j <= '0;
        end
        OP_FIT_EV: begin
          if (!st.fit_break) begin
            j <= j + CNT_W'(1);
            if (overlap && prd.pend > cur) cur <= prd.pend;
          end
        end
        OP_INS_START: ins_j <= placed_n;
        OP_INS_EV: begin
          if (st.ins_move) ins_j <= ins_prev;
        end
        OP_EMIT: begin
          res <= '{status: STAT_OK, placed_id: best.id, placed_offset: cur,
                   pool_size: pool_next, final_result: (k == count - CNT_W'(1))};
          pool <= pool_next;
          placed_n <= placed_n + CNT_W'(1);
        end
        OP_NEXT: begin
          k <= k + CNT_W'(1);
          best_found <= 1'b0;
          idx <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  assign out_data = res;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_BUFFERS))
    else $error("entry count exceeds table depth");
  a_sel_found: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_SEL_DONE) |-> best_found)
    else $error("selection pass closed without a candidate");
  a_placed_bound: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_EMIT) |-> (placed_n < count))
    else $error("placing more buffers than recorded");
`endif

endmodule

`default_nettype wire

// ===== design/labop_ctrl.sv =====
// Controller state machine sequencing table scans, selection, fitting and result beats.
`default_nettype none

module labop_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  wire                  out_stall,
  output labop_pkg::cmd_t      cmd,
  input  labop_pkg::dp_stat_t  st
);
  import labop_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DISPATCH = 4'd1;
  localparam logic [3:0] S_SCAN_RD = 4'd2;
  localparam logic [3:0] S_SCAN_EV = 4'd3;
  localparam logic [3:0] S_COMMIT = 4'd4;
  localparam logic [3:0] S_SEL_RD = 4'd5;
  localparam logic [3:0] S_SEL_EV = 4'd6;
  localparam logic [3:0] S_SEL_DONE = 4'd7;
  localparam logic [3:0] S_FIT = 4'd8;
  localparam logic [3:0] S_FIT_EV = 4'd9;
  localparam logic [3:0] S_INS = 4'd10;
  localparam logic [3:0] S_INS_EV = 4'd11;
  localparam logic [3:0] S_EMIT = 4'd12;
  localparam logic [3:0] S_OUT = 4'd13;

  logic [3:0] state;
  logic [3:0] state_next;

  // Next state and datapath command
  always_comb begin
    state_next = state;
    cmd.op = OP_NOP;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = OP_LOAD;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (st.func)
          FUNC_RECORD: state_next = st.size_zero ? S_OUT : S_SCAN_RD;
          FUNC_REMOVE: state_next = S_SCAN_RD;
          FUNC_PLAN: begin
            cmd.op = OP_PLAN_INIT;
            state_next = st.table_empty ? S_OUT : S_SEL_RD;
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_SCAN_RD: begin
        cmd.op = OP_ENT_RD;
        state_next = S_SCAN_EV;
      end
      S_SCAN_EV: begin
        cmd.op = OP_SCAN_EV;
        state_next = (st.hit_now || st.idx_last) ? S_COMMIT : S_SCAN_RD;
      end
      S_COMMIT: begin
        cmd.op = OP_COMMIT;
        state_next = S_OUT;
      end
      S_SEL_RD: begin
        cmd.op = OP_ENT_RD;
        state_next = S_SEL_EV;
      end
      S_SEL_EV: begin
        cmd.op = OP_SEL_EV;
        state_next = st.idx_last ? S_SEL_DONE : S_SEL_RD;
      end
      S_SEL_DONE: begin
        cmd.op = OP_SEL_DONE;
        state_next = S_FIT;
      end
      S_FIT: begin
        if (st.fit_done) begin
          cmd.op = OP_INS_START;
          state_next = S_INS;
        end else begin
          cmd.op = OP_FIT_RD;
          state_next = S_FIT_EV;
        end
      end
      S_FIT_EV: begin
        // A gap that fits ends the scan; go straight to insertion
        if (st.fit_break) begin
          cmd.op = OP_INS_START;
          state_next = S_INS;
        end else begin
          cmd.op = OP_FIT_EV;
          state_next = S_FIT;
        end
      end
      S_INS: begin
        if (st.ins_head) begin
          cmd.op = OP_INS_PUT;
          state_next = S_EMIT;
        end else begin
          cmd.op = OP_INS_RD;
          state_next = S_INS_EV;
        end
      end
      S_INS_EV: begin
        cmd.op = OP_INS_EV;
        state_next = st.ins_move ? S_INS : S_EMIT;
      end
      S_EMIT: begin
        cmd.op = OP_EMIT;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) begin
          cmd.op = OP_NEXT;
          state_next = st.res_final ? S_IDLE : S_SEL_RD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);
  assign out_valid = (state == S_OUT);

`ifndef SYNTH
  a_accept_dispatch: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_DISPATCH))
    else $error("accepted beat not dispatched");
  a_emit_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |=> out_valid)
    else $error("placement result not presented");
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while a result is pending");
`endif

endmodule

`default_nettype wire

// ===== design/lifetime_aware_buffer_offset_planner_top.sv =====
// Top level of the lifetime-aware buffer offset planner.
//
//   channel | direction | handshake            | beat
//   in      | input     | in_valid / in_stall  | in_data (func, id, use, size)
//   out     | output    | out_valid / out_stall| out_data (status, id, offset, pool, last)
//   cfg     | input     | cfg_wr_en            | cfg_wr_data (alignment_log2)
//
// One item at a time. Record and remove scan the table entry by entry. Plan
// takes, per buffer, a selection pass over the table, a fit scan over placed
// buffers and an insertion into the offset-ordered list.
// Synchronous reset clears the table valid bits; a stalled result beat holds.
`default_nettype none

module lifetime_aware_buffer_offset_planner_top (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  labop_pkg::in_item_t   in_data,
  output logic                  out_valid,
  input  wire                   out_stall,
  output labop_pkg::out_item_t  out_data,
  input  wire                   cfg_wr_en,
  input  wire  [3:0]            cfg_wr_data
);
  import labop_pkg::*;

  cmd_t     cmd;
  dp_stat_t st;

  labop_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .st        (st)
  );

  labop_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .in_data     (in_data),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

endmodule

`default_nettype wire
